FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL core. Each check uses clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every rising clock edge outside reset.
`define AST_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant check failed");

// Check a same-cycle implication.
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Check a next-cycle implication.
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/psd_pkg.sv
`default_nettype none
package psd_pkg;
	localparam int OUT_W = 43;
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	typedef logic [1:0] region_t;
	typedef logic [OUT_W-1:0] dist_t;

	localparam region_t REG_INSIDE = 2'd0;
	localparam region_t REG_START  = 2'd1;
	localparam region_t REG_END    = 2'd2;
endpackage
`default_nettype wire

FILE: rtl/point_segment_distance_squared_core.sv
`default_nettype none
// Squared distance from a point to a closed segment, fully pipelined.
// Input channel: in_valid / in_stall carry one beat per item: the point
// (pt_x, pt_y) and the segment (start_x, start_y) to (end_x, end_y), signed.
// Output channel: out_valid / out_stall carry dist_sq (unsigned, FRAC_BITS
// fraction bits, truncated, saturating at 2^43-1) and region (0 inside,
// 1 before start or zero length, 2 beyond end).
// Throughput: one beat per cycle while the receiver does not stall. The path
// from input beat to out_valid runs through six arithmetic stages, one
// restoring-division cell per quotient bit, and the output register.
// The divider is a row of identical cells; each retires one quotient bit
// and hands its remainder to the next cell every cycle the pipeline advances.
// Reset clears all valid flags; the pipeline comes up empty.
// When the receiver stalls, the output register holds its beat and a skid
// register catches the one beat in flight; while the skid is full the whole
// pipeline holds and in_stall is raised.
module point_segment_distance_squared_core #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] pt_x,
	input  wire logic signed [COORD_BITS-1:0] pt_y,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output psd_pkg::dist_t                    dist_sq,
	output psd_pkg::region_t                  region
);
	import psd_pkg::*;
`include "assert_macros.svh"

	localparam int DW = 2 * COORD_BITS + 2;
	localparam int QW = 2 * COORD_BITS + 3 + FRAC_BITS;
	localparam int RW = $bits(region_t);
	localparam int TW = RW + OUT_W;
	localparam int XW = (QW > OUT_W) ? QW : OUT_W;

	logic en;
	logic skid_v_q;
	logic out_v_q;
	dist_t skid_dist_q, out_dist_q;
	region_t skid_reg_q, out_reg_q;

	// chain taps, index 0 is the front-end output
	logic          c_v   [QW+1];
	logic [DW-1:0] c_den [QW+1];
	logic [DW-1:0] c_rem [QW+1];
	logic [QW-1:0] c_num [QW+1];
	logic [QW-1:0] c_q   [QW+1];
	logic [TW-1:0] c_tag [QW+1];

	region_t f_reg;
	dist_t   f_alt;

	// advance everything unless the skid register is occupied
	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	psd_front #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_i     (in_valid),
		.pt_x    (pt_x),
		.pt_y    (pt_y),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.v_o     (c_v[0]),
		.den_o   (c_den[0]),
		.rem_o   (c_rem[0]),
		.num_o   (c_num[0]),
		.region_o(f_reg),
		.alt_o   (f_alt)
	);

	assign c_q[0]   = '0;
	assign c_tag[0] = {f_reg, f_alt};

	for (genvar i = 0; i < QW; i++) begin : g_cell
		psd_div_cell #(
			.DW(DW),
			.QW(QW),
			.TW(TW)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_i   (c_v[i]),
			.den_i (c_den[i]),
			.rem_i (c_rem[i]),
			.num_i (c_num[i]),
			.q_i   (c_q[i]),
			.tag_i (c_tag[i]),
			.v_o   (c_v[i+1]),
			.den_o (c_den[i+1]),
			.rem_o (c_rem[i+1]),
			.num_o (c_num[i+1]),
			.q_o   (c_q[i+1]),
			.tag_o (c_tag[i+1])
		);
	end

	// final select: quotient for the inside case, endpoint distance otherwise
	logic [XW-1:0] qx;
	dist_t   q_sat;
	region_t tail_reg;
	dist_t   tail_alt;
	dist_t   tail_dist;

	assign qx        = XW'(c_q[QW]);
	assign q_sat     = (qx > XW'(OUT_MAX)) ? OUT_MAX : qx[OUT_W-1:0];
	assign tail_reg  = c_tag[QW][TW-1:OUT_W];
	assign tail_alt  = c_tag[QW][OUT_W-1:0];
	assign tail_dist = (tail_reg == REG_INSIDE) ? q_sat : tail_alt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= c_v[QW];
			end
		end else if (c_v[QW] && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			out_dist_q <= skid_v_q ? skid_dist_q : tail_dist;
			out_reg_q  <= skid_v_q ? skid_reg_q : tail_reg;
		end else if (c_v[QW] && en) begin
			skid_dist_q <= tail_dist;
			skid_reg_q  <= tail_reg;
		end
	end

	assign out_valid = out_v_q;
	assign dist_sq   = out_dist_q;
	assign region    = out_reg_q;

	// skid is only loaded behind a held output beat
	`AST_IMPL(a_skid_behind_out, skid_v_q, out_v_q)
	// a stalled output beat is never dropped
	`AST_NEXT(a_hold_on_stall, out_v_q && out_stall, out_v_q)
	// region code stays within its defined set
	`AST_IMPL(a_region_code, out_v_q,
		out_reg_q == REG_INSIDE || out_reg_q == REG_START || out_reg_q == REG_END)
endmodule
`default_nettype wire

FILE: rtl/psd_front.sv
`default_nettype none
module psd_front #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         v_i,
	input  wire logic signed [COORD_BITS-1:0] pt_x,
	input  wire logic signed [COORD_BITS-1:0] pt_y,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	output logic                              v_o,
	output logic [2*COORD_BITS+1:0]           den_o,
	output logic [2*COORD_BITS+1:0]           rem_o,
	output logic [2*COORD_BITS+2+FRAC_BITS:0] num_o,
	output psd_pkg::region_t                  region_o,
	output psd_pkg::dist_t                    alt_o
);
	import psd_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int DF = C + 1;
	localparam int P  = 2 * C + 2;
	localparam int DW = 2 * C + 2;
	localparam int SW = 2 * C + 3;
	localparam int LW = 2 * C + 4;
	localparam int CW = SW;
	localparam int H  = CW / 2;
	localparam int NW = 2 * SW + FRAC_BITS;
	localparam int QW = 2 * C + 3 + FRAC_BITS;
	localparam int XA = (LW > OUT_W) ? LW : OUT_W;

	// stage 1: differences
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [DF-1:0] dx_s1, dy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	// stage 2: products
	logic signed [P-1:0] dxx_s2, dyy_s2, vxdx_s2, vydy_s2, vxdy_s2, vydx_s2;
	logic signed [P-1:0] vxx_s2, vyy_s2, wxx_s2, wyy_s2;
	// stage 3: sums
	logic [DW-1:0] dd_s3;
	logic signed [SW-1:0] vd_s3, cr_s3;
	logic [LW-1:0] sv_s3, se_s3;
	// stage 4: region and endpoint distance
	logic [DW-1:0] dd_s4, dd_s5, dd_s6;
	logic [CW-1:0] c_s4;
	region_t reg_s4, reg_s5, reg_s6;
	dist_t alt_s4, alt_s5, alt_s6;
	// stage 5: split square
	logic [CW+H-1:0] plo_s5;
	logic [2*CW-H-1:0] phi_s5;
	// stage 6: numerator
	logic [NW-1:0] num_s6;

	logic [XA-1:0] svx, sex;
	logic sv_sat, se_sat;
	logic signed [SW-1:0] dd_sx;
	logic [2*CW-1:0] sq;

	assign svx    = XA'(sv_s3);
	assign sex    = XA'(se_s3);
	assign sv_sat = svx > XA'(OUT_MAX >> FRAC_BITS);
	assign se_sat = sex > XA'(OUT_MAX >> FRAC_BITS);
	assign dd_sx  = SW'({1'b0, dd_s3});
	assign sq     = (2*CW)'(plo_s5) + ((2*CW)'(phi_s5) << H);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DF'(end_x) - DF'(start_x);
			dy_s1 <= DF'(end_y) - DF'(start_y);
			vx_s1 <= DF'(pt_x) - DF'(start_x);
			vy_s1 <= DF'(pt_y) - DF'(start_y);
			wx_s1 <= DF'(pt_x) - DF'(end_x);
			wy_s1 <= DF'(pt_y) - DF'(end_y);

			dxx_s2  <= P'(dx_s1) * P'(dx_s1);
			dyy_s2  <= P'(dy_s1) * P'(dy_s1);
			vxdx_s2 <= P'(vx_s1) * P'(dx_s1);
			vydy_s2 <= P'(vy_s1) * P'(dy_s1);
			vxdy_s2 <= P'(vx_s1) * P'(dy_s1);
			vydx_s2 <= P'(vy_s1) * P'(dx_s1);
			vxx_s2  <= P'(vx_s1) * P'(vx_s1);
			vyy_s2  <= P'(vy_s1) * P'(vy_s1);
			wxx_s2  <= P'(wx_s1) * P'(wx_s1);
			wyy_s2  <= P'(wy_s1) * P'(wy_s1);

			dd_s3 <= DW'(dxx_s2) + DW'(dyy_s2);
			vd_s3 <= SW'(vxdx_s2) + SW'(vydy_s2);
			cr_s3 <= SW'(vxdy_s2) - SW'(vydx_s2);
			sv_s3 <= LW'(vxx_s2) + LW'(vyy_s2);
			se_s3 <= LW'(wxx_s2) + LW'(wyy_s2);

			dd_s4 <= dd_s3;
			c_s4  <= (cr_s3 < 0) ? CW'(-cr_s3) : CW'(cr_s3);
			if (dd_s3 == '0 || vd_s3 < 0) begin
				reg_s4 <= REG_START;
				alt_s4 <= sv_sat ? OUT_MAX : OUT_W'(svx << FRAC_BITS);
			end else if (vd_s3 > dd_sx) begin
				reg_s4 <= REG_END;
				alt_s4 <= se_sat ? OUT_MAX : OUT_W'(sex << FRAC_BITS);
			end else begin
				reg_s4 <= REG_INSIDE;
				alt_s4 <= '0;
			end

			plo_s5 <= (CW+H)'(c_s4) * (CW+H)'(c_s4[H-1:0]);
			phi_s5 <= (2*CW-H)'(c_s4) * (2*CW-H)'(c_s4[CW-1:H]);
			dd_s5  <= dd_s4;
			reg_s5 <= reg_s4;
			alt_s5 <= alt_s4;

			num_s6 <= NW'(sq) << FRAC_BITS;
			dd_s6  <= dd_s5;
			reg_s6 <= reg_s5;
			alt_s6 <= alt_s5;
		end
	end

	// high part of the numerator stays below the divisor when inside
	assign v_o      = v_s6;
	assign den_o    = dd_s6;
	assign rem_o    = DW'(num_s6[NW-1:QW]);
	assign num_o    = num_s6[QW-1:0];
	assign region_o = reg_s6;
	assign alt_o    = alt_s6;
endmodule
`default_nettype wire

FILE: rtl/psd_div_cell.sv
`default_nettype none
module psd_div_cell #(
	parameter int DW = 34,
	parameter int QW = 43,
	parameter int TW = 45
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          v_i,
	input  wire logic [DW-1:0] den_i,
	input  wire logic [DW-1:0] rem_i,
	input  wire logic [QW-1:0] num_i,
	input  wire logic [QW-1:0] q_i,
	input  wire logic [TW-1:0] tag_i,
	output logic               v_o,
	output logic [DW-1:0]      den_o,
	output logic [DW-1:0]      rem_o,
	output logic [QW-1:0]      num_o,
	output logic [QW-1:0]      q_o,
	output logic [TW-1:0]      tag_o
);
	logic [DW:0] trial;
	logic        ge;

	// one restoring step: bring down the next numerator bit
	assign trial = {rem_i, num_i[QW-1]};
	assign ge    = trial >= (DW+1)'(den_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o <= den_i;
			rem_o <= ge ? DW'(trial - (DW+1)'(den_i)) : DW'(trial);
			num_o <= num_i << 1;
			q_o   <= {q_i[QW-2:0], ge};
			tag_o <= tag_i;
		end
	end
endmodule
`default_nettype wire

FILE: dv/point_segment_distance_squared_core_test.sv
`default_nettype none
module point_segment_distance_squared_core_test;
	import psd_pkg::*;

	localparam int CB = 16;
	localparam int FB = 8;
	localparam int LATENCY = 2*CB + FB + 10;
	localparam int RANDOM_BEATS = 850;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic signed [CB-1:0] coord_t;

	typedef struct {
		coord_t px, py, sx, sy, ex, ey;
	} query_t;

	typedef struct {
		dist_t dist_val;
		region_t reg_code;
	} answer_t;

	// one directed beat; known = 1 when the answer is typed in
	typedef struct {
		query_t q;
		bit known;
		answer_t ans;
	} vector_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	coord_t pt_x = '0, pt_y = '0, start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic out_valid;
	logic out_stall = 0;
	dist_t dist_sq;
	region_t region;

	answer_t pending_answers[$];
	int errors = 0;
	longint cycles = 0;
	bit calm = 0;      // no idling in the final stretch

	point_segment_distance_squared_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pt_x(pt_x), .pt_y(pt_y), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.dist_sq(dist_sq), .region(region)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Compute the expected squared distance and region for one query.
	function automatic answer_t distance_to_segment(query_t q);
		longint dx, dy, vx, vy, dd, vd, wx, wy, cr;
		logic [127:0] num, quot;
		logic [127:0] sq;
		answer_t a;
		dx = longint'(q.ex) - q.sx;
		dy = longint'(q.ey) - q.sy;
		vx = longint'(q.px) - q.sx;
		vy = longint'(q.py) - q.sy;
		wx = longint'(q.px) - q.ex;
		wy = longint'(q.py) - q.ey;
		dd = dx*dx + dy*dy;
		vd = vx*dx + vy*dy;
		if (dd == 0 || vd < 0) begin
			a.reg_code = REG_START;
			sq = 128'(vx*vx + vy*vy) << FB;
		end else if (vd > dd) begin
			a.reg_code = REG_END;
			sq = 128'(wx*wx + wy*wy) << FB;
		end else begin
			a.reg_code = REG_INSIDE;
			cr = vx*dy - vy*dx;
			if (cr < 0) cr = -cr;
			num = (128'(cr) * 128'(cr)) << FB;
			quot = num / 128'(dd);
			sq = quot;
		end
		// saturate at the output width
		a.dist_val = (sq > 128'(OUT_MAX)) ? OUT_MAX : sq[OUT_W-1:0];
		return a;
	endfunction

	// Drive one beat and hold it until the block takes it.
	task automatic send_beat(query_t q);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		pt_x <= q.px; pt_y <= q.py;
		start_x <= q.sx; start_y <= q.sy;
		end_x <= q.ex; end_y <= q.ey;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'(16'h8000);
			1: return coord_t'(16'h7fff);
			2: return coord_t'($urandom_range(0, 31)) - coord_t'(16);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Record the expectation at acceptance so order matches the pipeline.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			pending_answers.push_back(distance_to_segment(
				'{pt_x, pt_y, start_x, start_y, end_x, end_y}));
		end
	end

	// Check every result beat against the oldest expectation.
	always @(posedge clk) begin
		answer_t want;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				$error("result beat with nothing pending: dist_sq %0d region %0d",
					dist_sq, region);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				if (dist_sq !== want.dist_val) begin
					$error("dist_sq expected %0d actual %0d", want.dist_val, dist_sq);
					errors++;
				end
				if (region !== want.reg_code) begin
					$error("region expected %0d actual %0d", want.reg_code, region);
					errors++;
				end
			end
		end
	end

	// Receiver back-pressure in random bursts; drop it near the end.
	initial begin
		int burst;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 11);
				out_stall <= 1;
				repeat (burst) @(negedge clk);
				out_stall <= 0;
			end
		end
	end

	// Hard stop on a hang.
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("point_segment_distance_squared_core: mismatch");
		$finish;
	end

	initial begin
		vector_t table_rows[$];
		query_t q;
		answer_t got;
		int wait_cycles;
		// zero-length segment at the origin: distance zero, start region
		table_rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, '{43'd0, REG_START}});
		// zero-length segment, point off it
		table_rows.push_back('{'{3, 4, 0, 0, 0, 0}, 1, '{43'd25 << FB, REG_START}});
		// point before start
		table_rows.push_back('{'{-3, 0, 0, 0, 10, 0}, 1, '{43'd9 << FB, REG_START}});
		// point beyond end
		table_rows.push_back('{'{14, 3, 0, 0, 10, 0}, 1, '{43'd25 << FB, REG_END}});
		// projection exactly on start and on end count as inside
		table_rows.push_back('{'{0, 5, 0, 0, 10, 0}, 1, '{43'd25 << FB, REG_INSIDE}});
		table_rows.push_back('{'{10, 5, 0, 0, 10, 0}, 1, '{43'd25 << FB, REG_INSIDE}});
		// interior with a fraction: point (1,0), segment (0,0)-(1,1): 1/2
		table_rows.push_back('{'{1, 0, 0, 0, 1, 1}, 1, '{43'd1 << (FB-1), REG_INSIDE}});
		// truncated repeating fraction
		table_rows.push_back('{'{1, 0, 0, 0, 1, 2}, 0, '{0, 0}});
		// extremes of the grid
		table_rows.push_back('{'{-32768, -32768, 32767, 32767, 32767, 32767}, 0, '{0, 0}});
		table_rows.push_back('{'{32767, 32767, -32768, -32768, -32768, -32768}, 0, '{0, 0}});
		table_rows.push_back('{'{-32768, 32767, -32768, -32768, 32767, 32767}, 0, '{0, 0}});
		table_rows.push_back('{'{32767, -32768, -32768, -32768, 32767, 32767}, 0, '{0, 0}});
		table_rows.push_back('{'{-32768, -32768, -32768, 32767, 32767, -32768}, 0, '{0, 0}});
		table_rows.push_back('{'{32767, 32767, -32768, 32767, 32767, -32768}, 0, '{0, 0}});
		table_rows.push_back('{'{-1, -1, 32767, -32768, -32768, 32767}, 0, '{0, 0}});
		table_rows.push_back('{'{-32768, 0, 32767, 0, 32767, 1}, 0, '{0, 0}});
		table_rows.push_back('{'{32767, -32768, 32767, 32767, -32768, -32768}, 0, '{0, 0}});

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		foreach (table_rows[i]) begin
			if (table_rows[i].known) begin
				got = distance_to_segment(table_rows[i].q);
				// typed-in answers also guard the predictor itself
				if (got.dist_val !== table_rows[i].ans.dist_val) begin
					$error("dist_sq expected %0d actual %0d",
						table_rows[i].ans.dist_val, got.dist_val);
					errors++;
				end
				if (got.reg_code !== table_rows[i].ans.reg_code) begin
					$error("region expected %0d actual %0d",
						table_rows[i].ans.reg_code, got.reg_code);
					errors++;
				end
			end
			send_beat(table_rows[i].q);
		end

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n == RANDOM_BEATS - 100) calm = 1;
			q.sx = pick_coord(); q.sy = pick_coord();
			case ($urandom_range(0, 4))
				0: begin  // degenerate segment
					q.ex = q.sx; q.ey = q.sy;
				end
				1: begin  // short segment near start
					q.ex = q.sx + coord_t'($urandom_range(0, 15)) - coord_t'(8);
					q.ey = q.sy + coord_t'($urandom_range(0, 15)) - coord_t'(8);
				end
				default: begin
					q.ex = pick_coord(); q.ey = pick_coord();
				end
			endcase
			if ($urandom_range(0, 2) == 0) begin
				// point close to the segment start
				q.px = q.sx + coord_t'($urandom_range(0, 63)) - coord_t'(32);
				q.py = q.sy + coord_t'($urandom_range(0, 63)) - coord_t'(32);
			end else begin
				q.px = pick_coord(); q.py = pick_coord();
			end
			send_beat(q);
		end
		in_valid <= 0;

		wait_cycles = 0;
		while (pending_answers.size() != 0 && wait_cycles < 20 * LATENCY) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		if (errors == 0 && pending_answers.size() == 0) begin
			$display("point_segment_distance_squared_core: match");
		end else begin
			$display("point_segment_distance_squared_core: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/psd_pkg.sv
rtl/psd_front.sv
rtl/psd_div_cell.sv
rtl/point_segment_distance_squared_core.sv
dv/point_segment_distance_squared_core_test.sv
